### rtl/btest_pkg.sv
package btest_pkg;

	localparam int unsigned RingDepthDefault = 30;

	localparam logic [31:0] TEMPO_NUM = 32'd15360000;

	localparam logic [31:0] WINDOW_RST = 32'd10000;
	localparam logic [15:0] MIN_IVL_RST = 16'd200;
	localparam logic [15:0] MAX_IVL_RST = 16'd2000;
	localparam logic [7:0] MIN_BPM_RST = 8'd40;
	localparam logic [7:0] MAX_BPM_RST = 8'd220;
	localparam logic [16:0] WEIGHT_RST = 17'd39322;

	typedef enum logic [2:0] {
		REG_WINDOW = 3'd0,
		REG_MIN_IVL = 3'd1,
		REG_MAX_IVL = 3'd2,
		REG_MIN_BPM = 3'd3,
		REG_MAX_BPM = 3'd4,
		REG_WEIGHT = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		SRC_FEW = 2'd0,
		SRC_NONE = 2'd1,
		SRC_MEDIAN = 2'd2,
		SRC_SPAN = 2'd3
	} src_t;

	localparam logic CMD_BEAT = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

endpackage

### rtl/btest_div.sv
module btest_div
	import btest_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  div_req_t req,
	output logic done,
	output logic [31:0] quot
);

	logic [32:0] rem_q;
	logic [31:0] q_q;
	logic [31:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [32:0] trial;
	logic fits;

	assign trial = {rem_q[31:0], q_q[31]};
	assign fits = trial >= {1'b0, den_q};

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			q_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			q_q <= {q_q[30:0], fits};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

### rtl/beat_tempo_estimator.sv
// beat tempo estimator
// command channel (cmd_valid/cmd_stall): command 0 records now_ms as a beat,
// command 1 asks for the tempo at now_ms. a beat gives no result; a query
// gives one result on the result channel (res_valid/res_stall) with bpm_q8
// (Q8.8), source and beats_in_window.
// a query walks the timestamp ring from the newest beat, with a memory read
// and a compare for each beat, storing kept intervals in a scratch memory.
// with more than two kept intervals the median is found by rank counting over
// the scratch memory. the division is a bit-serial unit, followed by clamp
// and smoothing.
// cmd_stall is high while a query is in work. the result sits in an output
// register, so a new command is taken while it waits; a stalled result only
// holds up the next query at its end.
// reset empties the ring, clears the last tempo and loads register defaults.
// the config port (cfg_valid/cfg_ready) is always ready; write it while idle.
module beat_tempo_estimator
	import btest_pkg::*;
#(
	parameter int unsigned RING_DEPTH = RingDepthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  logic command,
	input  logic [31:0] now_ms,
	output logic res_valid,
	input  logic res_stall,
	output logic [15:0] bpm_q8,
	output logic [1:0] source,
	output logic [6:0] beats_in_window,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned SLOT_W = $clog2(RING_DEPTH);
	localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE, ST_WALK_RD, ST_WALK_EV, ST_DECIDE, ST_SEL_CAND, ST_SEL_CWT,
		ST_SEL_IN, ST_SEL_CHK, ST_MED, ST_DIV_GO, ST_DIV_WT, ST_SM1, ST_SM2,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [31:0] window_q;
	logic [15:0] min_ivl_q, max_ivl_q;
	logic [7:0] min_bpm_q, max_bpm_q;
	logic [16:0] weight_q;

	logic [31:0] stamp_mem [RING_DEPTH];
	logic [15:0] scratch_mem [RING_DEPTH-1];
	logic [31:0] stamp_rdata_q;
	logic [15:0] sc_rdata_q;
	logic [SLOT_W-1:0] sc_raddr;

	logic [SLOT_W-1:0] write_slot_q, slot_q;
	logic [CNT_W-1:0] stored_q, n_q, kept_q, i_q, j_q, lt_q, le_q, ka_q, kb_q;
	logic [31:0] now_q, prev_q, raw_q;
	logic [15:0] last_bpm_q, ma_q, mb_q, cand_q, clamp_q, pend_bpm_q;
	logic [1:0] pend_src_q;
	logic [32:0] prod_q;
	logic vld_s1;

	logic res_valid_q;
	logic [15:0] bpm_q;
	logic [1:0] src_q;
	logic [6:0] nwin_q;

	div_req_t div_req_q;
	logic div_done;
	logic [31:0] div_quot;

	logic cmd_acc, cfg_acc;
	logic [31:0] age, ivl, span;
	logic [15:0] lo, hi, clamped;
	logic [31:0] raw_lo;
	logic [16:0] w_sat, w_inv, msum;
	logic [33:0] smooth_sum;
	logic [CNT_W-1:0] lt_n, le_n;

	assign cmd_stall = state_q != ST_IDLE;
	assign cmd_acc = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;
	assign cfg_acc = cfg_valid && cfg_ready;

	assign age = now_q - stamp_rdata_q;
	assign ivl = prev_q - stamp_rdata_q;
	assign span = now_q - prev_q;
	assign lo = {min_bpm_q, 8'h00};
	assign hi = {max_bpm_q, 8'h00};
	assign raw_lo = (raw_q < {16'h0, lo}) ? {16'h0, lo} : raw_q;
	assign clamped = (raw_lo > {16'h0, hi}) ? hi : raw_lo[15:0];
	assign w_sat = weight_q[16] ? 17'h10000 : weight_q;
	assign w_inv = 17'h10000 - w_sat;
	assign smooth_sum = {1'b0, prod_q} + 34'(w_inv * last_bpm_q);
	assign msum = {1'b0, ma_q} + {1'b0, mb_q};
	assign lt_n = lt_q + CNT_W'(vld_s1 && sc_rdata_q < cand_q);
	assign le_n = le_q + CNT_W'(vld_s1 && sc_rdata_q <= cand_q);
	assign sc_raddr = (state_q == ST_SEL_CAND) ? i_q[SLOT_W-1:0] : j_q[SLOT_W-1:0];

	btest_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req_q),
		.done(div_done),
		.quot(div_quot)
	);

	always_ff @(posedge clk) begin
		if (cmd_acc && command == CMD_BEAT)
			stamp_mem[write_slot_q] <= now_ms;
		stamp_rdata_q <= stamp_mem[slot_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WALK_EV && age <= window_q && n_q != '0 &&
				ivl > {16'h0, min_ivl_q} && ivl < {16'h0, max_ivl_q})
			scratch_mem[kept_q[SLOT_W-1:0]] <= ivl[15:0];
		sc_rdata_q <= scratch_mem[sc_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
			min_ivl_q <= MIN_IVL_RST;
			max_ivl_q <= MAX_IVL_RST;
			min_bpm_q <= MIN_BPM_RST;
			max_bpm_q <= MAX_BPM_RST;
			weight_q <= WEIGHT_RST;
		end else if (cfg_acc) begin
			case (cfg_index)
				REG_WINDOW: window_q <= cfg_data;
				REG_MIN_IVL: min_ivl_q <= cfg_data[15:0];
				REG_MAX_IVL: max_ivl_q <= cfg_data[15:0];
				REG_MIN_BPM: min_bpm_q <= cfg_data[7:0];
				REG_MAX_BPM: max_bpm_q <= cfg_data[7:0];
				REG_WEIGHT: weight_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			write_slot_q <= '0;
			stored_q <= '0;
			last_bpm_q <= '0;
			res_valid_q <= 1'b0;
			div_req_q <= '0;
			vld_s1 <= 1'b0;
			slot_q <= '0;
			n_q <= '0;
			kept_q <= '0;
			i_q <= '0;
			j_q <= '0;
			lt_q <= '0;
			le_q <= '0;
		end else begin
			div_req_q.start <= 1'b0;
			if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						if (command == CMD_BEAT) begin
							write_slot_q <= (write_slot_q == LAST_SLOT) ? '0 :
								write_slot_q + 1'b1;
							if (stored_q < DEPTH_CNT)
								stored_q <= stored_q + 1'b1;
						end else begin
							now_q <= now_ms;
							slot_q <= (write_slot_q == '0) ? LAST_SLOT :
								write_slot_q - 1'b1;
							n_q <= '0;
							kept_q <= '0;
							state_q <= ST_WALK_RD;
						end
					end
				end
				ST_WALK_RD: begin
					state_q <= (n_q < stored_q) ? ST_WALK_EV : ST_DECIDE;
				end
				ST_WALK_EV: begin
					if (age > window_q) begin
						state_q <= ST_DECIDE;
					end else begin
						if (n_q != '0 && ivl > {16'h0, min_ivl_q} &&
								ivl < {16'h0, max_ivl_q})
							kept_q <= kept_q + 1'b1;
						prev_q <= stamp_rdata_q;
						n_q <= n_q + 1'b1;
						slot_q <= (slot_q == '0) ? LAST_SLOT : slot_q - 1'b1;
						state_q <= ST_WALK_RD;
					end
				end
				ST_DECIDE: begin
					if (n_q < CNT_W'(2)) begin
						pend_bpm_q <= lo;
						pend_src_q <= SRC_FEW;
						state_q <= ST_DONE;
					end else if (kept_q == '0) begin
						pend_bpm_q <= (last_bpm_q != '0) ? last_bpm_q : lo;
						pend_src_q <= SRC_NONE;
						state_q <= ST_DONE;
					end else if (kept_q > CNT_W'(2)) begin
						pend_src_q <= SRC_MEDIAN;
						kb_q <= kept_q >> 1;
						ka_q <= kept_q[0] ? (kept_q >> 1) : (kept_q >> 1) - 1'b1;
						i_q <= '0;
						state_q <= ST_SEL_CAND;
					end else begin
						pend_src_q <= SRC_SPAN;
						if (span == '0) begin
							raw_q <= '1;
							state_q <= ST_SM1;
						end else begin
							div_req_q.num <= 32'((n_q - 1'b1) * TEMPO_NUM);
							div_req_q.den <= span;
							state_q <= ST_DIV_GO;
						end
					end
				end
				ST_SEL_CAND: begin
					state_q <= ST_SEL_CWT;
				end
				ST_SEL_CWT: begin
					cand_q <= sc_rdata_q;
					j_q <= '0;
					lt_q <= '0;
					le_q <= '0;
					vld_s1 <= 1'b0;
					state_q <= ST_SEL_IN;
				end
				ST_SEL_IN: begin
					// one scratch read issued per cycle, compared in the following cycle
					lt_q <= lt_n;
					le_q <= le_n;
					if (j_q < kept_q) begin
						j_q <= j_q + 1'b1;
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1)
							state_q <= ST_SEL_CHK;
					end
				end
				ST_SEL_CHK: begin
					if (lt_q <= ka_q && ka_q < le_q)
						ma_q <= cand_q;
					if (lt_q <= kb_q && kb_q < le_q)
						mb_q <= cand_q;
					i_q <= i_q + 1'b1;
					state_q <= (i_q + 1'b1 == kept_q) ? ST_MED : ST_SEL_CAND;
				end
				ST_MED: begin
					div_req_q.num <= TEMPO_NUM;
					div_req_q.den <= {16'h0, msum[16:1]};
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					div_req_q.start <= 1'b1;
					state_q <= ST_DIV_WT;
				end
				ST_DIV_WT: begin
					if (div_done) begin
						raw_q <= div_quot;
						state_q <= ST_SM1;
					end
				end
				ST_SM1: begin
					clamp_q <= clamped;
					prod_q <= 33'(w_sat * clamped);
					state_q <= ST_SM2;
				end
				ST_SM2: begin
					if (last_bpm_q == '0) begin
						pend_bpm_q <= clamp_q;
						last_bpm_q <= clamp_q;
					end else begin
						pend_bpm_q <= smooth_sum[31:16];
						last_bpm_q <= smooth_sum[31:16];
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						bpm_q <= pend_bpm_q;
						src_q <= pend_src_q;
						nwin_q <= 7'(n_q);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign bpm_q8 = bpm_q;
	assign source = src_q;
	assign beats_in_window = nwin_q;

	a_stored_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= DEPTH_CNT) else $error("stored beat count past ring depth");

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q < DEPTH_CNT) else $error("kept intervals past scratch depth");

	a_median_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && source == SRC_MEDIAN |-> beats_in_window >= 7'd4)
		else $error("median result with too few windowed beats");

	a_few_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && source == SRC_FEW |-> beats_in_window < 7'd2)
		else $error("too-few result with two or more windowed beats");

endmodule
